### sv/block_bitmap_allocator_assert.svh
// assertion macros for the block bitmap allocator
// used by block_bitmap_allocator.sv; needs no other file
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BBA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bba: same-cycle check failed");
// next-cycle implication
`define BBA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bba: next-cycle check failed");
`else
`define BBA_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BBA_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

### sv/bba_pkg.sv
// shared types and constants of the block bitmap allocator
// no dependencies; imported by every module of the block
`default_nettype none

package bba_pkg;

    // default geometry
    localparam int unsigned BBA_STORE_BLOCKS    = 1024;
    localparam int unsigned BBA_RESERVED_BLOCKS = 131;
    localparam int unsigned BBA_BITMAP_WORDS    = 32;

    // field widths
    localparam int unsigned CNT_W    = 11;
    localparam int unsigned ID_W     = 10;
    localparam int unsigned BID_W    = 16;
    localparam int unsigned ODATA_W  = 40;
    localparam int unsigned PADDR_W  = 3;

    localparam logic [CNT_W-1:0] USABLE_RESET = 11'd1024;

    // register index of usable_blocks
    localparam logic REG_USABLE = 1'b0;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_ALLOCATED    = 2'd0;
    localparam logic [1:0] STAT_NO_VACANT    = 2'd1;
    localparam logic [1:0] STAT_FREE_OK      = 2'd2;
    localparam logic [1:0] STAT_OUT_OF_RANGE = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic ptr_step;
        logic init_write;
        logic alloc_commit;
        logic alloc_fail;
        logic free_bad;
        logic free_commit;
        logic out_load;
    } bba_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic room;
        logic found;
        logic last_word;
        logic range_bad;
        logic init_last;
        logic out_free;
    } bba_stat_t;

endpackage

`default_nettype wire

### sv/bba_ctrl.sv
// sequencing state machine of the block bitmap allocator
// depends on bba_pkg for the command and status structs
`default_nettype none

module bba_ctrl
    import bba_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      req_type,
    input  bba_stat_t stat,
    output logic      s_tready,
    output bba_cmd_t  cmd
);

    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_ALLOC_RD = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_FREE_RD  = 3'd4;
    localparam logic [2:0] S_FREE_UPD = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: begin
                cmd.init_write = 1'b1;
                cmd.ptr_step   = 1'b1;
                if (stat.init_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = (req_type == REQ_FREE) ? S_FREE_RD : S_ALLOC_RD;
                end
            end
            S_ALLOC_RD: begin
                cmd.ptr_step = 1'b1;
                if (!stat.room) begin
                    cmd.alloc_fail = 1'b1;
                    state_next     = S_RESP;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.ptr_step = 1'b1;
                if (stat.found) begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = S_RESP;
                end else if (stat.last_word) begin
                    cmd.alloc_fail = 1'b1;
                    state_next     = S_RESP;
                end
            end
            S_FREE_RD: begin
                if (stat.range_bad) begin
                    cmd.free_bad = 1'b1;
                    state_next   = S_RESP;
                end else begin
                    state_next = S_FREE_UPD;
                end
            end
            S_FREE_UPD: begin
                cmd.free_commit = 1'b1;
                state_next      = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

### sv/bba_datapath.sv
// bitmap memory, word scanner, counters and result register of the allocator
// depends on bba_pkg; driven by bba_ctrl through bba_cmd_t
`default_nettype none

module bba_datapath
    import bba_pkg::*;
#(
    parameter int unsigned STORE_BLOCKS    = BBA_STORE_BLOCKS,
    parameter int unsigned RESERVED_BLOCKS = BBA_RESERVED_BLOCKS,
    parameter int unsigned BITMAP_WORDS    = BBA_BITMAP_WORDS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] usable_blocks,
    input  logic             req_type,
    input  logic [BID_W-1:0] block_id,
    input  bba_cmd_t         cmd,
    output bba_stat_t        stat,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [1:0]       m_status,
    output logic [ID_W-1:0]  m_alloc_id,
    output logic             m_already_free,
    output logic [CNT_W-1:0] m_used_count,
    output logic [CNT_W-1:0] m_vacant_count
);

    localparam int unsigned WORD_W      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int unsigned MAP_BITS    = BITMAP_WORDS * 32;
    localparam int unsigned BLOCK_LIMIT = (STORE_BLOCKS < MAP_BITS) ? STORE_BLOCKS : MAP_BITS;
    localparam int unsigned RESV_LIMIT  =
        (RESERVED_BLOCKS < BLOCK_LIMIT) ? RESERVED_BLOCKS : BLOCK_LIMIT;

    localparam logic [31:0] ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] TOP  = 32'h8000_0000;

    logic [31:0]       mem [BITMAP_WORDS];
    logic [31:0]       rd_data_reg;
    logic [WORD_W-1:0] word_ptr_reg;
    logic [WORD_W-1:0] word_ptr_next;
    logic [WORD_W-1:0] chk_ptr_reg;
    logic [BID_W-1:0]  block_id_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [1:0]        status_reg;
    logic [ID_W-1:0]   grant_reg;
    logic              was_free_reg;

    logic              m_tvalid_reg;
    logic [1:0]        m_status_reg;
    logic [ID_W-1:0]   m_alloc_id_reg;
    logic              m_already_free_reg;
    logic [CNT_W-1:0]  m_used_reg;
    logic [CNT_W-1:0]  m_vacant_reg;

    logic [CNT_W-1:0]  eff;
    logic [CNT_W-1:0]  eff_m1;
    logic [5:0]        tail_bits;
    logic              is_last;
    logic [31:0]       scan_mask;
    logic [31:0]       free_bits;
    logic              hit;
    logic [4:0]        hit_pos;
    logic [31:0]       set_word;
    logic [31:0]       free_sel;
    logic              bit_set;
    logic [31:0]       clr_word;
    logic [31:0]       init_base;
    logic [31:0]       init_word;
    logic              wr_en;
    logic [WORD_W-1:0] wr_addr;
    logic [31:0]       wr_data;

    // effective usable size, capped at the store
    assign eff       = (32'(usable_blocks) < BLOCK_LIMIT) ? usable_blocks : CNT_W'(BLOCK_LIMIT);
    assign eff_m1    = eff - CNT_W'(1);
    assign tail_bits = {1'b0, eff_m1[4:0]} + 6'd1;
    assign is_last   = (32'(chk_ptr_reg) == 32'(eff_m1[CNT_W-1:5]));

    // only blocks below the usable size take part in the scan
    assign scan_mask = is_last ? ~(ONES >> tail_bits) : ONES;
    assign free_bits = ~rd_data_reg & scan_mask;

    // lowest block sits in the msb
    always_comb begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = 0; i < 32; i++) begin
            if (free_bits[31-i] && !hit) begin
                hit     = 1'b1;
                hit_pos = 5'(i);
            end
        end
    end

    assign set_word = rd_data_reg | (TOP >> hit_pos);
    assign free_sel = TOP >> block_id_reg[4:0];
    assign bit_set  = |(rd_data_reg & free_sel);
    assign clr_word = rd_data_reg & ~free_sel;

    // reset image of one word
    assign init_base = 32'(word_ptr_reg) << 5;
    always_comb begin
        if (init_base + 32'd32 <= RESV_LIMIT) begin
            init_word = ONES;
        end else if (init_base >= RESV_LIMIT) begin
            init_word = '0;
        end else begin
            init_word = ~(ONES >> 6'(RESV_LIMIT - init_base));
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = chk_ptr_reg;
        wr_data = set_word;
        if (cmd.init_write) begin
            wr_en   = 1'b1;
            wr_addr = word_ptr_reg;
            wr_data = init_word;
        end else if (cmd.alloc_commit) begin
            wr_en = 1'b1;
        end else if (cmd.free_commit && bit_set) begin
            wr_en   = 1'b1;
            wr_data = clr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[word_ptr_reg];
        chk_ptr_reg <= word_ptr_reg;
    end

    always_comb begin
        word_ptr_next = word_ptr_reg;
        if (cmd.capture) begin
            word_ptr_next = (req_type == REQ_ALLOC) ? '0 : WORD_W'(32'(block_id) >> 5);
        end else if (cmd.ptr_step && (32'(word_ptr_reg) != BITMAP_WORDS - 1)) begin
            word_ptr_next = word_ptr_reg + WORD_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_ptr_reg <= '0;
            used_reg     <= CNT_W'(RESV_LIMIT);
            m_tvalid_reg <= 1'b0;
        end else begin
            word_ptr_reg <= word_ptr_next;
            if (cmd.alloc_commit) begin
                used_reg <= used_reg + CNT_W'(1);
            end else if (cmd.free_commit && bit_set && (used_reg != '0)) begin
                used_reg <= used_reg - CNT_W'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            block_id_reg <= block_id;
        end
        if (cmd.alloc_commit) begin
            status_reg   <= STAT_ALLOCATED;
            grant_reg    <= ID_W'({chk_ptr_reg, hit_pos});
            was_free_reg <= 1'b0;
        end else if (cmd.alloc_fail) begin
            status_reg   <= STAT_NO_VACANT;
            grant_reg    <= '0;
            was_free_reg <= 1'b0;
        end else if (cmd.free_bad) begin
            status_reg   <= STAT_OUT_OF_RANGE;
            grant_reg    <= '0;
            was_free_reg <= 1'b0;
        end else if (cmd.free_commit) begin
            status_reg   <= STAT_FREE_OK;
            grant_reg    <= '0;
            was_free_reg <= !bit_set;
        end
        if (cmd.out_load) begin
            m_status_reg       <= status_reg;
            m_alloc_id_reg     <= grant_reg;
            m_already_free_reg <= was_free_reg;
            m_used_reg         <= used_reg;
            m_vacant_reg       <= (eff > used_reg) ? eff - used_reg : '0;
        end
    end

    assign stat.room      = (used_reg < eff);
    assign stat.found     = hit;
    assign stat.last_word = is_last;
    assign stat.range_bad = (32'(block_id_reg) < RESERVED_BLOCKS) ||
                            (32'(block_id_reg) >= BLOCK_LIMIT);
    assign stat.init_last = (32'(word_ptr_reg) == BITMAP_WORDS - 1);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid       = m_tvalid_reg;
    assign m_status       = m_status_reg;
    assign m_alloc_id     = m_alloc_id_reg;
    assign m_already_free = m_already_free_reg;
    assign m_used_count   = m_used_reg;
    assign m_vacant_count = m_vacant_reg;

endmodule

`default_nettype wire

### sv/block_bitmap_allocator.sv
// allocate: room check, then a scan of bitmap words, one a cycle, to the first free bit or last
// usable word; no-room allocate and out-of-range free answer after the check; free reads the word,
// then writes it back; one request at a time, the next taken once the last result is in the output
// register, which waits while a previous result is not taken on m_tready; aresetn low
// (synchronous) restores the register and counters, then the bitmap is rewritten one word a cycle
// top level of the block bitmap allocator; uses bba_pkg, bba_ctrl, bba_datapath
`default_nettype none

`include "block_bitmap_allocator_assert.svh"

module block_bitmap_allocator
    import bba_pkg::*;
#(
    parameter int unsigned STORE_BLOCKS    = BBA_STORE_BLOCKS,
    parameter int unsigned RESERVED_BLOCKS = BBA_RESERVED_BLOCKS,
    parameter int unsigned BITMAP_WORDS    = BBA_BITMAP_WORDS
) (
    input  logic               aclk,
    input  logic               aresetn,

    // request channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BID_W-1:0]   s_tdata,   // [15:0] block_id
    input  logic [0:0]         s_tuser,   // [0] req_type

    // result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    // [9:0] alloc_id, [10] already_free, [21:11] used_count,
    // [32:22] vacant_count, [39:33] zero
    output logic [ODATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,   // [1:0] status

    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned MAP_BITS_TOP    = BITMAP_WORDS * 32;
    localparam int unsigned BLOCK_LIMIT_TOP =
        (STORE_BLOCKS < MAP_BITS_TOP) ? STORE_BLOCKS : MAP_BITS_TOP;

    logic [CNT_W-1:0] usable_reg;
    logic             reg_sel;
    logic             cfg_write;

    bba_cmd_t         cmd;
    bba_stat_t        stat;

    logic [1:0]       res_status;
    logic [ID_W-1:0]  res_alloc_id;
    logic             res_already_free;
    logic [CNT_W-1:0] res_used;
    logic [CNT_W-1:0] res_vacant;

    logic             res_granted;
    logic             res_failed;
    logic             grant_ok;

    // register file: a single 11-bit register at byte address 0
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            usable_reg <= USABLE_RESET;
        end else if (cfg_write && (reg_sel == REG_USABLE)) begin
            // upper data bits are dropped
            usable_reg <= pwdata[CNT_W-1:0];
        end
    end

    // unknown addresses read as zero
    assign prdata = (reg_sel == REG_USABLE) ? 32'(usable_reg) : '0;

    // sequencer: init sweep, request dispatch, scan control, result hand-off
    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser[0]),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // bitmap memory, scanner, used count and output register
    bba_datapath #(
        .STORE_BLOCKS    (STORE_BLOCKS),
        .RESERVED_BLOCKS (RESERVED_BLOCKS),
        .BITMAP_WORDS    (BITMAP_WORDS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .usable_blocks  (usable_reg),
        .req_type       (s_tuser[0]),
        .block_id       (s_tdata),
        .cmd            (cmd),
        .stat           (stat),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_status       (res_status),
        .m_alloc_id     (res_alloc_id),
        .m_already_free (res_already_free),
        .m_used_count   (res_used),
        .m_vacant_count (res_vacant)
    );

    // result packing, lowest field first
    assign m_tdata = {7'd0, res_vacant, res_used, res_already_free, res_alloc_id};
    assign m_tuser = res_status;

    // result classes watched by the checks below
    assign res_granted = m_tvalid && (res_status == STAT_ALLOCATED);
    assign res_failed  = m_tvalid &&
                         ((res_status == STAT_NO_VACANT) || (res_status == STAT_OUT_OF_RANGE));
    assign grant_ok    = (BLOCK_LIMIT_TOP > 1024) || (32'(res_alloc_id) >= RESERVED_BLOCKS);

    // one request in flight: an accepted transfer closes the input side
    `BBA_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a reserved block is never granted
    `BBA_ASSERT_IMP(a_no_reserved_grant, aclk, aresetn, res_granted, grant_ok)

    // failed requests carry no grant and no already-free flag
    `BBA_ASSERT_IMP(a_fail_clean, aclk, aresetn, res_failed, !res_already_free && !(|res_alloc_id))

endmodule

`default_nettype wire

### tb/sv/block_bitmap_allocator_tb.sv
// self-checking bench for block_bitmap_allocator: allocate and free requests are streamed in,
// each result is predicted from a bit-per-block copy of the usage map and compared on arrival
// depends on bba_pkg and the block's rtl only

module block_bitmap_allocator_tb;
    import bba_pkg::*;

    // geometry as the block is built by default
    localparam int unsigned STORE_BLKS  = BBA_STORE_BLOCKS;
    localparam int unsigned RESV_BLKS   = BBA_RESERVED_BLOCKS;
    localparam int unsigned MAP_BLKS    = BBA_BITMAP_WORDS * 32;
    localparam int unsigned BLOCK_LIMIT = (STORE_BLKS < MAP_BLKS) ? STORE_BLKS : MAP_BLKS;
    localparam int unsigned RESV_LIMIT  = (RESV_BLKS < BLOCK_LIMIT) ? RESV_BLKS : BLOCK_LIMIT;

    // register map: usable_blocks at byte 0, the next word decodes to nothing
    localparam logic [PADDR_W-1:0] USABLE_ADDR   = {REG_USABLE, 2'b00};
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

    localparam int unsigned MAX_REPORTS   = 10;
    // longest allocate scans every bitmap word; the settle wait is sized from the word count
    localparam int unsigned SETTLE_CYCLES = BBA_BITMAP_WORDS + 8;
    localparam int unsigned CHUNK_ITEMS   = 50;

    // one result, fields in the order they are checked
    typedef struct packed {
        logic [1:0]          status;
        logic [ID_W-1:0]     alloc_id;
        logic                already_free;
        logic [CNT_W-1:0]    used_count;
        logic [CNT_W-1:0]    vacant_count;
        logic [ODATA_W-34:0] pad;
    } alloc_outcome_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [BID_W-1:0]   s_tdata  = '0;
    logic [0:0]         s_tuser  = REQ_ALLOC;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [ODATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state: usage bit per block, used count, register copy
    bit                 blk_used [BLOCK_LIMIT];
    int unsigned        used_total;
    logic [CNT_W-1:0]   usable_reg;

    alloc_outcome_t     pending_outcomes [$];
    alloc_outcome_t     seen_outcome;
    alloc_outcome_t     want_outcome;
    int unsigned        fail_count    = 0;
    int unsigned        src_idle_pct  = 37;
    int unsigned        sink_idle_pct = 73;

    block_bitmap_allocator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // failures are all counted, only the first few are described
    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("mismatch @%0t: %s", $realtime, what);
        end
    endfunction

    // usage map as it stands right after reset
    function automatic void model_reset();
        int unsigned b;
        for (b = 0; b < BLOCK_LIMIT; b++) begin
            blk_used[b] = (b < RESV_LIMIT);
        end
        used_total = RESV_LIMIT;
        usable_reg = USABLE_RESET;
    endfunction

    // applies one request to the usage map and returns the result it must produce
    function automatic alloc_outcome_t bitmap_outcome(input logic kind,
                                                      input logic [BID_W-1:0] id);
        alloc_outcome_t o;
        int unsigned    eff;
        int unsigned    b;
        int unsigned    vac;
        bit             hit;
        o   = '0;
        hit = 1'b0;
        // register value capped at what the map can hold
        eff = (usable_reg < BLOCK_LIMIT) ? usable_reg : BLOCK_LIMIT;
        if (kind == REQ_ALLOC) begin
            o.status = STAT_NO_VACANT;
            // lowest clear bit below the usable size wins
            if (used_total < eff) begin
                for (b = 0; b < eff && !hit; b++) begin
                    if (!blk_used[b]) begin
                        blk_used[b] = 1'b1;
                        used_total++;
                        o.status   = STAT_ALLOCATED;
                        o.alloc_id = b[ID_W-1:0];
                        hit        = 1'b1;
                    end
                end
            end
        end else if (id < RESV_BLKS || id >= BLOCK_LIMIT) begin
            // reserved area or past the end of the store
            o.status = STAT_OUT_OF_RANGE;
        end else begin
            o.status = STAT_FREE_OK;
            if (!blk_used[id]) begin
                o.already_free = 1'b1;
            end else begin
                blk_used[id] = 1'b0;
                if (used_total > 0) used_total--;
            end
        end
        vac            = (eff > used_total) ? eff - used_total : 0;
        o.used_count   = used_total[CNT_W-1:0];
        o.vacant_count = vac[CNT_W-1:0];
        return o;
    endfunction

    // one request transfer; valid stays up into the next request unless a gap is drawn
    task automatic send_request(input logic kind, input logic [BID_W-1:0] id);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= id;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_outcomes.push_back(bitmap_outcome(kind, id));
    endtask

    // block quiet: no request offered, every result back, scan finished
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // setup cycle, then access cycle; the write lands at the access edge
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == USABLE_ADDR) usable_reg = value[CNT_W-1:0];
    endtask

    // read back usable_blocks and compare with the predictor's copy
    task automatic read_usable();
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= USABLE_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {{(32-CNT_W){1'b0}}, usable_reg}) begin
            note_failure($sformatf("usable_blocks read: expected %0d, got %h",
                                   usable_reg, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random back-pressure, each transfer checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_outcome.status       = m_tuser;
            seen_outcome.alloc_id     = m_tdata[9:0];
            seen_outcome.already_free = m_tdata[10];
            seen_outcome.used_count   = m_tdata[21:11];
            seen_outcome.vacant_count = m_tdata[32:22];
            seen_outcome.pad          = m_tdata[ODATA_W-1:33];
            if (pending_outcomes.size() == 0) begin
                note_failure($sformatf("result with nothing pending: status %0d data %h",
                                       m_tuser, m_tdata));
            end else begin
                want_outcome = pending_outcomes.pop_front();
                if (seen_outcome !== want_outcome) begin
                    note_failure($sformatf({
                        "expected st %0d id %0d af %0b used %0d vac %0d pad %0h, ",
                        "got st %0d id %0d af %0b used %0d vac %0d pad %0h"},
                        want_outcome.status, want_outcome.alloc_id, want_outcome.already_free,
                        want_outcome.used_count, want_outcome.vacant_count, want_outcome.pad,
                        seen_outcome.status, seen_outcome.alloc_id, seen_outcome.already_free,
                        seen_outcome.used_count, seen_outcome.vacant_count, seen_outcome.pad));
                end
            end
        end
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // register reset value, first grant lands just above the reserved area
    task automatic test_reset_state();
        read_usable();
        send_request(REQ_ALLOC, 16'hFFFF);
    endtask

    // free at both edges of the reserved area and of the store, plus a double free
    task automatic test_free_range();
        send_request(REQ_FREE, 16'd0);
        send_request(REQ_FREE, 16'(RESV_BLKS - 1));
        send_request(REQ_FREE, 16'(RESV_BLKS));
        send_request(REQ_FREE, 16'(RESV_BLKS));
        send_request(REQ_FREE, 16'(BLOCK_LIMIT - 1));
        send_request(REQ_FREE, 16'(BLOCK_LIMIT));
        send_request(REQ_FREE, 16'hFFFF);
    endtask

    // usable size at and below the reserved area, one above, over the store, unmapped write
    task automatic test_usable_size();
        write_reg(USABLE_ADDR, RESV_BLKS);
        send_request(REQ_ALLOC, 16'h0000);
        write_reg(USABLE_ADDR, 32'd0);
        send_request(REQ_ALLOC, 16'h5555);
        read_usable();
        write_reg(USABLE_ADDR, RESV_BLKS + 1);
        send_request(REQ_ALLOC, 16'hAAAA);
        send_request(REQ_ALLOC, 16'h0000);
        // freeing past the usable size is still an ordinary free
        send_request(REQ_FREE, 16'd600);
        write_reg(USABLE_ADDR, 32'hFFFF_F7FF);
        send_request(REQ_ALLOC, 16'h0000);
        read_usable();
        write_reg(UNMAPPED_ADDR, 32'd133);
        send_request(REQ_ALLOC, 16'h0000);
    endtask

    // fill a small device, punch a hole, confirm the hole is granted next
    task automatic test_fill_and_reuse();
        write_reg(USABLE_ADDR, 32'd140);
        repeat (7) send_request(REQ_ALLOC, 16'h0000);
        send_request(REQ_FREE, 16'd136);
        send_request(REQ_ALLOC, 16'h0000);
        write_reg(USABLE_ADDR, 32'(USABLE_RESET));
    endtask

    // chunks of mixed traffic, each under a fresh usable size and allocate bias
    task automatic test_random_traffic(input int unsigned n_items,
                                       input int unsigned src_pct,
                                       input int unsigned sink_pct);
        int unsigned      sent;
        int unsigned      alloc_pct;
        int unsigned      span_hi;
        logic             kind;
        logic [BID_W-1:0] id;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < n_items) begin
            // small sizes fill up quickly and exercise the full-map path
            case ($urandom_range(3))
                0: begin
                    write_reg(USABLE_ADDR, $urandom_range(200, RESV_BLKS + 1));
                end
                1: begin
                    write_reg(USABLE_ADDR, $urandom);
                end
                2: begin
                    write_reg(USABLE_ADDR, 32'(USABLE_RESET));
                end
                default: begin
                    write_reg(USABLE_ADDR, $urandom_range(400, RESV_BLKS + 1));
                end
            endcase
            alloc_pct = $urandom_range(90, 20);
            span_hi   = (usable_reg < BLOCK_LIMIT) ? usable_reg : BLOCK_LIMIT;
            if (span_hi <= RESV_LIMIT + 1) span_hi = RESV_LIMIT + 16;
            repeat (CHUNK_ITEMS) begin
                if ($urandom_range(99) < alloc_pct) begin
                    kind = REQ_ALLOC;
                    id   = 16'($urandom);
                end else begin
                    kind = REQ_FREE;
                    // mostly blocks that may be in use, some junk ids
                    case ($urandom_range(9))
                        0: begin
                            id = 16'($urandom);
                        end
                        1: begin
                            id = 16'($urandom_range(RESV_BLKS - 1));
                        end
                        2: begin
                            id = 16'($urandom_range(16'hFFFF, BLOCK_LIMIT));
                        end
                        3: begin
                            id = 16'($urandom_range(BLOCK_LIMIT - 1, RESV_BLKS));
                        end
                        default: begin
                            id = 16'($urandom_range(span_hi - 1, RESV_BLKS));
                        end
                    endcase
                end
                send_request(kind, id);
                sent++;
            end
        end
    endtask

    initial begin
        model_reset();
        // reset is held, then released; the block then clears its map with s_tready low
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_free_range();
        test_usable_size();
        test_fill_and_reuse();

        // sender sparse and receiver stalling, then swapped, then full speed
        test_random_traffic(550, 37, 73);
        test_random_traffic(550, 73, 37);
        test_random_traffic(550, 0, 0);

        wait_idle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
